// ===== rtl/bbsf_pkg.sv =====
// Package for the bounded byte stream FIFO: request and result structs,
// operation codes and register constants. No dependencies.
package bbsf_pkg;

	localparam int unsigned CAP_W = 13;
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

	// Operation codes; unused codes behave as a query
	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_POP   = 3'd1;
	localparam logic [2:0] OP_CLOSE = 3'd2;
	localparam logic [2:0] OP_ERROR = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  data_byte;
		logic [15:0] pop_length;
	} cmd_t;

	typedef struct packed {
		logic        accepted;
		logic [7:0]  front_byte;
		logic        front_valid;
		logic [12:0] buffered_count;
		logic [63:0] pushed_total;
		logic [63:0] popped_total;
		logic        closed_flag;
		logic        error_flag;
		logic        finished_flag;
	} rsp_t;

endpackage

// ===== rtl/bbsf_store.sv =====
// Byte store of the FIFO: one write port and one registered read port.
// Depends on nothing but the depth parameter passed from the top level.
module bbsf_store #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	// Write the pushed byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read data, old value on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bounded_byte_stream_fifo_core.sv =====
// Top level of the bounded byte stream FIFO: pointers, counts, flags and
// result formation around the byte store. Uses bbsf_pkg and bbsf_store.
//
//  Channel   Signals                    Handshake
//  request   start, busy, cmd           taken when start is high and busy low
//  result    done, rsp                  one-cycle strobe, cannot be held off
//  config    cfg_we, cfg_wdata          capacity written when cfg_we is high
//
// One request is taken every cycle; its result appears in the next cycle.
// The result comes through the registered read port of the byte store,
// read at the read pointer the request leaves behind.
// busy never rises: pointers and counts settle at the edge that takes a request.
// Reset clears pointers, counts and flags and sets capacity to 4096; the
// byte store needs no clearing as an entry's read data is used only after it is written.
module bounded_byte_stream_fifo_core
	import bbsf_pkg::*;
#(
	parameter int unsigned DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CAP_MAX = (1 << CAP_W) - 1;
	localparam int unsigned HOLD_MAX = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
	localparam int unsigned CW = $clog2(HOLD_MAX + 1);

	logic [AW-1:0]    rp_q, wp_q, rp_next, wp_inc;
	logic [CW-1:0]    held_q, pop_n;
	logic [63:0]      tin_q, tout_q;
	logic             closed_q, error_q;
	logic [CAP_W-1:0] cap_q;
	logic             acc_q, fwd_q, done_q;
	logic [7:0]       fwd_byte_q, rdata;
	logic             take, is_push, is_pop, room, push_ok;
	logic [AW:0]      rp_sum;

	assign busy = 1'b0;
	assign take = start && !busy;

	// Decode the request and check for room
	assign is_push = (cmd.opcode == OP_PUSH);
	assign is_pop  = (cmd.opcode == OP_POP);
	assign room    = (CAP_W'(held_q) < cap_q) && (32'(held_q) < DEPTH);
	assign push_ok = take && is_push && room;

	// Pop length limited to the bytes held
	assign pop_n = (17'(cmd.pop_length) < 17'(held_q)) ? CW'(cmd.pop_length) : held_q;

	// Advance the read pointer with a single wrap correction
	assign rp_sum  = (AW+1)'(rp_q) + (AW+1)'(pop_n);
	assign rp_next = (take && is_pop) ?
		((rp_sum >= (AW+1)'(DEPTH)) ? AW'(rp_sum - (AW+1)'(DEPTH)) : AW'(rp_sum)) : rp_q;
	assign wp_inc  = (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + AW'(1);

	bbsf_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (push_ok),
		.waddr(wp_q),
		.wdata(cmd.data_byte),
		.re   (take),
		.raddr(rp_next),
		.rdata(rdata)
	);

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Update pointers, counts and flags for each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q     <= '0;
			wp_q     <= '0;
			held_q   <= '0;
			tin_q    <= '0;
			tout_q   <= '0;
			closed_q <= 1'b0;
			error_q  <= 1'b0;
			acc_q    <= 1'b0;
			fwd_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				acc_q <= push_ok;
				// Forward a byte pushed into an empty store
				fwd_q <= push_ok && (held_q == '0);
				case (cmd.opcode)
					OP_PUSH: begin
						if (room) begin
							wp_q   <= wp_inc;
							held_q <= held_q + CW'(1);
							tin_q  <= tin_q + 64'd1;
						end
					end
					OP_POP: begin
						rp_q   <= rp_next;
						held_q <= held_q - pop_n;
						tout_q <= tout_q + 64'(pop_n);
					end
					OP_CLOSE: closed_q <= 1'b1;
					OP_ERROR: error_q  <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// Capture the forwarded byte
	always_ff @(posedge clk) begin
		if (take) begin
			fwd_byte_q <= cmd.data_byte;
		end
	end

	// Form the result from the settled state
	always_comb begin
		rsp.accepted       = acc_q;
		rsp.front_valid    = (held_q != '0);
		rsp.front_byte     = (held_q == '0) ? 8'd0 : (fwd_q ? fwd_byte_q : rdata);
		rsp.buffered_count = 13'(held_q);
		rsp.pushed_total   = tin_q;
		rsp.popped_total   = tout_q;
		rsp.closed_flag    = closed_q;
		rsp.error_flag     = error_q;
		rsp.finished_flag  = closed_q && (held_q == '0);
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_count_matches_totals: assert property (@(posedge clk) disable iff (!arst_n)
		(tin_q - tout_q) == 64'(held_q))
		else $error("held count disagrees with pushed and popped totals");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(held_q) <= DEPTH)
		else $error("held count exceeds store depth");

	a_accept_grows_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.accepted) |-> (32'(held_q) == 32'($past(held_q)) + 1))
		else $error("accepted push did not grow the held count");

	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed flag fell");

	a_pointer_gap: assert property (@(posedge clk) disable iff (!arst_n)
		((wp_q >= rp_q) ? (32'(wp_q) - 32'(rp_q)) : (32'(wp_q) + DEPTH - 32'(rp_q)))
		== ((32'(held_q) == DEPTH) ? 32'd0 : 32'(held_q)))
		else $error("pointer gap disagrees with held count");
`endif

endmodule

// ===== sim/bbsf_status_checker.sv =====
// Status checker for the bounded byte stream FIFO: mirrors the FIFO state,
// predicts the status for each request and compares it with each result.
// Depends on bbsf_pkg.
`timescale 1ns / 1ps

module bbsf_status_checker
	import bbsf_pkg::*;
#(
	parameter int unsigned DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  cmd_t             cmd,
	input  logic             done,
	input  rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output int unsigned      fail_count,
	output int unsigned      due_count
);

	localparam int unsigned DUE_SLOTS = 16;

	// Mirror of the FIFO state
	logic [7:0]       byte_copy [DEPTH];
	int unsigned      rd_ptr;
	int unsigned      wr_ptr;
	int unsigned      held;
	logic [63:0]      bytes_in;
	logic [63:0]      bytes_out;
	logic             closed_seen;
	logic             error_seen;
	logic [CAP_W-1:0] capacity;

	// Status expected for each request taken, oldest at due_head
	rsp_t        status_due [DUE_SLOTS];
	int unsigned due_head;
	int unsigned due_tail;

	initial begin
		fail_count = 0;
		due_count  = 0;
	end

	// Print one line per mismatch and count it
	task automatic note_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field,
			got, want);
		fail_count++;
	endtask

	// Advance the mirror by one request and form the status that follows it
	task automatic apply_request(input cmd_t req, output rsp_t status);
		int unsigned room;
		int unsigned take;
		room   = (capacity > DEPTH) ? DEPTH : capacity;
		status = '0;
		case (req.opcode)
			OP_PUSH: begin
				if (held < room) begin
					byte_copy[wr_ptr] = req.data_byte;
					wr_ptr = (wr_ptr + 1) % DEPTH;
					held++;
					bytes_in++;
					status.accepted = 1'b1;
				end
			end
			OP_POP: begin
				take = (req.pop_length < held) ? req.pop_length : held;
				rd_ptr = (rd_ptr + take) % DEPTH;
				held -= take;
				bytes_out += take;
			end
			OP_CLOSE: closed_seen = 1'b1;
			OP_ERROR: error_seen = 1'b1;
			default: ;
		endcase
		status.front_valid    = (held != 0);
		status.front_byte     = (held != 0) ? byte_copy[rd_ptr] : 8'd0;
		status.buffered_count = held[CAP_W-1:0];
		status.pushed_total   = bytes_in;
		status.popped_total   = bytes_out;
		status.closed_flag    = closed_seen;
		status.error_flag     = error_seen;
		status.finished_flag  = closed_seen && (held == 0);
	endtask

	// Compare results, predict each request taken, track the register
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t fresh;
		if (!arst_n) begin
			rd_ptr      = 0;
			wr_ptr      = 0;
			held        = 0;
			bytes_in    = '0;
			bytes_out   = '0;
			closed_seen = 1'b0;
			error_seen  = 1'b0;
			capacity    = CAP_RESET;
			due_head    = 0;
			due_tail    = 0;
			due_count   = 0;
		end else begin
			if (done) begin
				if (due_tail == due_head) begin
					note_mismatch("unexpected result", rsp.buffered_count, '0);
				end else begin
					want = status_due[due_head % DUE_SLOTS];
					due_head++;
					if (rsp.accepted !== want.accepted)
						note_mismatch("accepted", rsp.accepted, want.accepted);
					if (rsp.front_byte !== want.front_byte)
						note_mismatch("front_byte", rsp.front_byte, want.front_byte);
					if (rsp.front_valid !== want.front_valid)
						note_mismatch("front_valid", rsp.front_valid, want.front_valid);
					if (rsp.buffered_count !== want.buffered_count)
						note_mismatch("buffered_count", rsp.buffered_count,
							want.buffered_count);
					if (rsp.pushed_total !== want.pushed_total)
						note_mismatch("pushed_total", rsp.pushed_total, want.pushed_total);
					if (rsp.popped_total !== want.popped_total)
						note_mismatch("popped_total", rsp.popped_total, want.popped_total);
					if (rsp.closed_flag !== want.closed_flag)
						note_mismatch("closed_flag", rsp.closed_flag, want.closed_flag);
					if (rsp.error_flag !== want.error_flag)
						note_mismatch("error_flag", rsp.error_flag, want.error_flag);
					if (rsp.finished_flag !== want.finished_flag)
						note_mismatch("finished_flag", rsp.finished_flag,
							want.finished_flag);
				end
			end
			// A request taken at this edge still sees the old capacity
			if (start && !busy) begin
				apply_request(cmd, fresh);
				if (due_tail - due_head >= DUE_SLOTS) begin
					note_mismatch("results outstanding", 64'(due_tail - due_head),
						64'(DUE_SLOTS));
				end else begin
					status_due[due_tail % DUE_SLOTS] = fresh;
					due_tail++;
				end
			end
			if (cfg_we) begin
				capacity = cfg_wdata;
			end
			due_count = due_tail - due_head;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the bounded byte stream FIFO: clock, reset, requests and
// capacity writes, and the verdict. Depends on bbsf_pkg, the FIFO core and
// bbsf_status_checker.
`timescale 1ns / 1ps

module tb_top;
	import bbsf_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             cmd;
	logic             done;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int unsigned      fail_count;
	int unsigned      due_count;
	bit               steady;

	bounded_byte_stream_fifo_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	bbsf_status_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle the request side now and then, unless in a steady stretch
	function automatic bit take_gap();
		return !steady && ($urandom_range(99) < 29);
	endfunction

	// Hold one request until it is taken
	task automatic issue_request(input cmd_t req);
		logic was_busy;
		while (take_gap()) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= req;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
	endtask

	task automatic issue_op(input logic [2:0] op, input logic [7:0] data,
			input logic [15:0] len);
		cmd_t req;
		req.opcode     = op;
		req.data_byte  = data;
		req.pop_length = len;
		issue_request(req);
	endtask

	// Wait until every outstanding status has come back
	task automatic wait_drained();
		do @(negedge clk); while (due_count != 0);
		@(posedge clk);
	endtask

	// Write the capacity register with the FIFO idle
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		start <= 1'b0;
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Push-heavy mix with mostly short pops so the FIFO fills and drains
	function automatic cmd_t random_request();
		cmd_t req;
		int unsigned pick;
		req.data_byte  = 8'($urandom);
		req.pop_length = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 52) begin
			req.opcode = OP_PUSH;
		end else if (pick < 76) begin
			req.opcode = OP_POP;
			pick = $urandom_range(99);
			if (pick < 70)
				req.pop_length = 16'($urandom_range(0, 6));
			else if (pick < 80)
				req.pop_length = 16'hFFFF;
		end else if (pick < 80) begin
			req.opcode = OP_CLOSE;
		end else if (pick < 84) begin
			req.opcode = OP_ERROR;
		end else if (pick < 92) begin
			req.opcode = OP_QUERY;
		end else begin
			req.opcode = 3'($urandom_range(OP_QUERY + 1, 7));
		end
		return req;
	endfunction

	initial begin
		logic [CAP_W-1:0] phase_caps [7];
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		steady    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, tiny capacity, drops, odd codes, flags
		write_capacity(13'd3);
		issue_op(OP_QUERY, 8'h00, 16'd0);
		issue_op(OP_POP, 8'h00, 16'd0);
		issue_op(OP_POP, 8'hFF, 16'hFFFF);
		issue_op(OP_PUSH, 8'h00, 16'd0);
		issue_op(OP_PUSH, 8'hFF, 16'hFFFF);
		issue_op(OP_PUSH, 8'hA5, 16'd0);
		issue_op(OP_PUSH, 8'h5A, 16'd0);
		issue_op(OP_POP, 8'h00, 16'd0);
		issue_op(OP_POP, 8'h00, 16'd1);
		issue_op(3'd5, 8'h11, 16'd2);
		issue_op(3'd6, 8'h22, 16'd2);
		issue_op(3'd7, 8'h33, 16'd2);
		issue_op(OP_POP, 8'h00, 16'hFFFF);
		issue_op(OP_CLOSE, 8'h00, 16'd0);
		issue_op(OP_PUSH, 8'h3C, 16'd0);
		issue_op(OP_QUERY, 8'h00, 16'd0);
		issue_op(OP_ERROR, 8'h00, 16'd0);
		issue_op(OP_POP, 8'h00, 16'd1);

		// Zero capacity: every push drops
		write_capacity(13'd0);
		issue_op(OP_PUSH, 8'h81, 16'd0);
		issue_op(OP_POP, 8'h00, 16'd1);
		issue_op(OP_QUERY, 8'h00, 16'd0);

		// Saturated capacity: a long steady run of pushes, back to back
		write_capacity(13'h1FFF);
		steady = 1'b1;
		for (int i = 0; i < 200; i++) begin
			issue_op(OP_PUSH, 8'($urandom), 16'($urandom));
		end
		steady = 1'b0;

		// Lower capacity under the held count: full until pops make room
		write_capacity(13'd2);
		for (int i = 0; i < 40; i++) begin
			issue_request(random_request());
		end

		// Random phases across a spread of capacities
		phase_caps = '{13'd4096, 13'd1, 13'd16, 13'h1FFF, 13'd5,
			13'($urandom_range(0, 8191)), 13'd64};
		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			steady = (p == 2);
			for (int i = 0; i < 90; i++) begin
				issue_request(random_request());
			end
		end
		steady = 1'b0;

		// Drain, allow for stray strobes, then give the verdict
		start <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Guard against a hang
	initial begin
		#200_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bbsf_pkg.sv
rtl/bbsf_store.sv
rtl/bounded_byte_stream_fifo_core.sv
sim/bbsf_status_checker.sv
sim/tb_top.sv
